// File: src/dmrt_pkg.sv
// ----------------------------------------------------------------------------
// dmrt_pkg: shared types and codes for the delayed message release table
// Beat payloads, front-to-back command format and result codes.
// ----------------------------------------------------------------------------
package dmrt_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int MSG_W         = 24;
    localparam int DELAY_W       = 16;
    localparam int TIME_W        = 32;

    // input mode codes
    localparam logic MODE_ENQ  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // result kind codes
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // enqueue status codes
    localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_ZERO     = 2'd2;

    // command codes after classification
    localparam logic [1:0] OP_ENQ    = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_IGNORE = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [MSG_W-1:0]   message;
        logic [DELAY_W-1:0] delay_ms;
    } item_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         status;
        logic [MSG_W-1:0]   released_message;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [MSG_W-1:0]   message;
        logic [DELAY_W-1:0] delay_ms;
    } cmd_t;

endpackage

// File: src/dmrt_front.sv
// ----------------------------------------------------------------------------
// dmrt_front: input classifier and two-entry command queue
// Accepts input beats, sorts them into tick, enqueue or ignore commands and
// buffers them for the back end.
// ----------------------------------------------------------------------------
module dmrt_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  dmrt_pkg::item_t      req,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output dmrt_pkg::cmd_t       cmd
);

    dmrt_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     fill_reg;
    logic [1:0]     fill_next;
    logic           push;
    logic           pop;
    dmrt_pkg::cmd_t cls;

    // classify the incoming beat
    always_comb
    begin
        cls.message  = req.message;
        cls.delay_ms = req.delay_ms;
        if (req.mode == dmrt_pkg::MODE_TICK)
        begin
            cls.op = dmrt_pkg::OP_TICK;
        end
        else if (req.delay_ms == '0)
        begin
            cls.op = dmrt_pkg::OP_IGNORE;
        end
        else
        begin
            cls.op = dmrt_pkg::OP_ENQ;
        end
    end

    assign req_ready = (fill_reg != 2'd2);
    assign push      = req_valid && req_ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    // advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// File: src/dmrt_back.sv
// ----------------------------------------------------------------------------
// dmrt_back: slot table executor
// Holds the time counter, slot valid bits and slot memories; runs enqueue
// searches and tick scans and drives the result register.
// ----------------------------------------------------------------------------
module dmrt_back
#(
    parameter int SLOTS = dmrt_pkg::SLOTS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  dmrt_pkg::cmd_t       cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output dmrt_pkg::result_t    rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
    localparam int TW = dmrt_pkg::TIME_W;
    localparam int DW = dmrt_pkg::DELAY_W;
    localparam int MW = dmrt_pkg::MSG_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ENQ    = 3'd1;
    localparam logic [2:0] ST_TICK   = 3'd2;
    localparam logic [2:0] ST_FLUSH  = 3'd3;
    localparam logic [2:0] ST_STATUS = 3'd4;

    // slot memories
    logic [TW-1:0] start_mem [SLOTS];
    logic [DW-1:0] delay_mem [SLOTS];
    logic [MW-1:0] msg_mem   [SLOTS];

    logic [2:0]       state_reg,      state_next;
    logic [CNT_W-1:0] scan_reg,       scan_next;
    logic             rd_valid_reg,   rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg,     rd_idx_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [MW-1:0]    pend_msg_reg,   pend_msg_next;
    logic [1:0]       status_reg,     status_next;
    logic [TW-1:0]    now_reg,        now_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic [SLOTS-1:0] active_reg,     active_next;
    logic [MW-1:0]    cur_msg_reg,    cur_msg_next;
    logic [DW-1:0]    cur_delay_reg,  cur_delay_next;
    logic             out_valid_reg,  out_valid_next;
    dmrt_pkg::result_t out_reg,       out_next;

    logic [TW-1:0]    rd_start_reg;
    logic [DW-1:0]    rd_delay_reg;
    logic [MW-1:0]    rd_msg_reg;

    logic [IDX_W-1:0] scan_idx;
    logic [IDX_W-1:0] mem_addr;
    logic [TW-1:0]    elapsed;
    logic             rd_hit;
    logic             out_free;
    logic             stall;
    logic             issue;
    logic             mem_we;
    logic             out_load;

    assign scan_idx  = scan_reg[IDX_W-1:0];
    assign out_free  = !out_valid_reg || rsp_ready;
    assign elapsed   = now_reg - rd_start_reg;
    assign rd_hit    = rd_valid_reg && active_reg[rd_idx_reg]
                       && (elapsed > {{(TW-DW){1'b0}}, rd_delay_reg});
    // a second release with the pending slot and result register both full
    assign stall     = rd_hit && pend_valid_reg && !out_free;
    assign issue     = (state_reg == ST_TICK) && !stall && (scan_reg < SLOTS_CNT);
    assign mem_addr  = stall ? rd_idx_reg : scan_idx;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // sequence the current command
    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        rd_valid_next   = rd_valid_reg;
        rd_idx_next     = rd_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_msg_next   = pend_msg_reg;
        status_next     = status_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        active_next     = active_reg;
        cur_msg_next    = cur_msg_reg;
        cur_delay_next  = cur_delay_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_next        = out_reg;
        mem_we          = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        dmrt_pkg::OP_TICK:
                        begin
                            now_next      = now_reg + TW'(1);
                            scan_next     = '0;
                            rd_valid_next = 1'b0;
                            state_next    = ST_TICK;
                        end
                        dmrt_pkg::OP_ENQ:
                        begin
                            if (count_reg == SLOTS_CNT)
                            begin
                                status_next = dmrt_pkg::STATUS_FULL;
                                state_next  = ST_STATUS;
                            end
                            else
                            begin
                                cur_msg_next   = cmd.message;
                                cur_delay_next = cmd.delay_ms;
                                scan_next      = '0;
                                state_next     = ST_ENQ;
                            end
                        end
                        default:
                        begin
                            status_next = dmrt_pkg::STATUS_ZERO;
                            state_next  = ST_STATUS;
                        end
                    endcase
                end
            end
            ST_ENQ:
            begin
                // take the lowest free slot, one slot per cycle
                if (!active_reg[scan_idx])
                begin
                    mem_we                = 1'b1;
                    active_next[scan_idx] = 1'b1;
                    count_next            = count_reg + CNT_W'(1);
                    status_next           = dmrt_pkg::STATUS_ACCEPTED;
                    state_next            = ST_STATUS;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            ST_TICK:
            begin
                if (!stall)
                begin
                    // retire the slot read last cycle
                    if (rd_hit)
                    begin
                        active_next[rd_idx_reg] = 1'b0;
                        count_next              = count_reg - CNT_W'(1);
                        pend_msg_next           = rd_msg_reg;
                        pend_valid_next         = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_load        = 1'b1;
                            out_valid_next  = 1'b1;
                            out_next.kind   = dmrt_pkg::KIND_RELEASE;
                            out_next.status = dmrt_pkg::STATUS_ACCEPTED;
                            out_next.released_message = pend_msg_reg;
                            out_next.last   = 1'b0;
                        end
                    end
                    rd_valid_next = issue;
                    rd_idx_next   = scan_idx;
                    if (issue)
                    begin
                        scan_next = scan_reg + CNT_W'(1);
                    end
                end
                if ((scan_reg == SLOTS_CNT) && !rd_valid_reg)
                begin
                    state_next = pend_valid_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                // final release carries the last mark
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_next.kind   = dmrt_pkg::KIND_RELEASE;
                    out_next.status = dmrt_pkg::STATUS_ACCEPTED;
                    out_next.released_message = pend_msg_reg;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_STATUS:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_next.kind   = dmrt_pkg::KIND_STATUS;
                    out_next.status = status_reg;
                    out_next.released_message = '0;
                    out_next.last   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            status_reg     <= dmrt_pkg::STATUS_ACCEPTED;
            now_reg        <= '0;
            count_reg      <= '0;
            active_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            rd_valid_reg   <= rd_valid_next;
            rd_idx_reg     <= rd_idx_next;
            pend_valid_reg <= pend_valid_next;
            status_reg     <= status_next;
            now_reg        <= now_next;
            count_reg      <= count_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_msg_reg  <= pend_msg_next;
        cur_msg_reg   <= cur_msg_next;
        cur_delay_reg <= cur_delay_next;
        out_reg       <= out_next;
    end

    // slot memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            start_mem[scan_idx] <= now_reg;
            delay_mem[scan_idx] <= cur_delay_reg;
            msg_mem[scan_idx]   <= cur_msg_reg;
        end
        rd_start_reg <= start_mem[mem_addr];
        rd_delay_reg <= delay_mem[mem_addr];
        rd_msg_reg   <= msg_mem[mem_addr];
    end

`ifndef SYNTHESIS
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'($countones(active_reg)) == count_reg)
        else $error("occupied count disagrees with slot valid bits");

    a_flush_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> pend_valid_reg)
        else $error("flush without a pending release");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result register overwritten before it was taken");

    a_enq_finds_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENQ) |-> (scan_reg < SLOTS_CNT))
        else $error("enqueue search ran past the table");
`endif

endmodule

// File: src/delayed_message_release_table.sv
// An enqueue beat passes the command queue; the back end then walks the
// valid bits one slot per cycle to the lowest free slot and sends a status.
// A tick scans all SLOTS slots through the registered read port; its last
// release, marked last, follows the scan and waits while the output stalls.
// One item is in work at a time and two more wait in the queue. Reset clears
// time, slot valid bits and the occupied count; slot memories are not cleared.
// ----------------------------------------------------------------------------
// delayed_message_release_table: timed slot table for delayed message release
// Front end classifies input beats into a short queue; back end runs them
// against the slot table and returns status and release results.
// ----------------------------------------------------------------------------
module delayed_message_release_table
#(
    parameter int SLOTS = dmrt_pkg::SLOTS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  dmrt_pkg::item_t      req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output dmrt_pkg::result_t    rsp
);

    logic           cmd_valid;
    logic           cmd_ready;
    dmrt_pkg::cmd_t cmd;

    dmrt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    dmrt_back
    #(
        .SLOTS (SLOTS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
